// File: rtl/core/mse_pkg.sv
// Shared types and constants for the merge sort engine.
`timescale 1ns / 1ps

package mse_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int VALUE_BITS_DEF = 16;
  localparam int SAMPLE_BITS    = 16;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   final_item;
  } mse_in_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sorted_value;
    logic                   end_of_set;
  } mse_out_item_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PRIME,
    ST_MERGE,
    ST_EMIT
  } mse_state_t;

  typedef struct packed {
    logic load;
    logic sort_init;
    logic pass_init;
    logic merge_step;
    logic emit_init;
    logic emit_step;
    logic set_done;
  } mse_cmd_t;

  typedef struct packed {
    logic sorted;
    logic pass_last;
    logic emit_last;
    logic out_free;
  } mse_status_t;

endpackage

// File: rtl/core/merge_sort_engine_unit.sv
// Top level of the merge sort engine: controller plus datapath.
`timescale 1ns / 1ps

// Values enter one per cycle on the load channel while the block is loading; the item
// with final_item set closes the set, and items past DEPTH are dropped (a dropped final
// item still closes the set). The stored N values are then sorted by bottom-up merge
// passes: ceil(log2 N) passes, each a prime state and then the merge state, in which one
// merged value is written to the scratch bank per cycle. A last prime state primes the
// bank read, then results leave one per cycle while the output register is free, smallest
// first, with end_of_set on the last. No new value is taken until the last result of a
// set has entered the output register.
module merge_sort_engine_unit
  import mse_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          load_valid,
  output logic          load_ready,
  input  mse_in_item_t  load_item,
  output logic          result_valid,
  input  logic          result_ready,
  output mse_out_item_t result_item
);

  mse_cmd_t    cmd;
  mse_status_t status;

  mse_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .load_valid (load_valid),
    .final_item (load_item.final_item),
    .status     (status),
    .load_ready (load_ready),
    .cmd        (cmd)
  );

  mse_datapath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .load_item    (load_item),
    .cmd          (cmd),
    .result_ready (result_ready),
    .status       (status),
    .result_valid (result_valid),
    .result_item  (result_item)
  );

endmodule

// File: rtl/core/mse_ctrl.sv
// Sequencer for load, merge passes and result emission.
`timescale 1ns / 1ps

module mse_ctrl
  import mse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load_valid,
  input  logic        final_item,
  input  mse_status_t status,
  output logic        load_ready,
  output mse_cmd_t    cmd
);

  mse_state_t state;
  mse_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    load_ready = 1'b0;
    unique case (state)
      ST_LOAD: begin
        load_ready = 1'b1;
        if (load_valid) begin
          cmd.load = 1'b1;
          if (final_item) begin
            cmd.sort_init = 1'b1;
            state_next    = ST_PRIME;
          end
        end
      end
      ST_PRIME: begin
        if (status.sorted) begin
          cmd.emit_init = 1'b1;
          state_next    = ST_EMIT;
        end else begin
          cmd.pass_init = 1'b1;
          state_next    = ST_MERGE;
        end
      end
      ST_MERGE: begin
        cmd.merge_step = 1'b1;
        if (status.pass_last) begin
          state_next = ST_PRIME;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit_step = 1'b1;
          if (status.emit_last) begin
            cmd.set_done = 1'b1;
            state_next   = ST_LOAD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

// File: rtl/core/mse_datapath.sv
// Value banks, merge pointers, compare and result register of the sort engine.
`timescale 1ns / 1ps

module mse_datapath
  import mse_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  mse_in_item_t  load_item,
  input  mse_cmd_t      cmd,
  input  logic          result_ready,
  output mse_status_t   status,
  output logic          result_valid,
  output mse_out_item_t result_item
);

  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);
  localparam int WID_BITS  = CNT_BITS + 1;
  localparam int SUM_BITS  = CNT_BITS + 2;

  logic [VALUE_BITS-1:0] bank0 [DEPTH];
  logic [VALUE_BITS-1:0] bank1 [DEPTH];
  logic [VALUE_BITS-1:0] rd_a;
  logic [VALUE_BITS-1:0] rd_b;

  logic [CNT_BITS-1:0] count, count_next;
  logic [WID_BITS-1:0] width, width_next;
  logic                src, src_next;
  logic [CNT_BITS-1:0] a, a_next;
  logic [CNT_BITS-1:0] b, b_next;
  logic [CNT_BITS-1:0] k, k_next;
  logic [CNT_BITS-1:0] mid, mid_next;
  logic [CNT_BITS-1:0] hi, hi_next;

  logic                  full;
  logic                  take_left;
  logic                  group_end;
  logic [VALUE_BITS-1:0] merged;
  logic [SUM_BITS-1:0]   grp_base;
  logic [SUM_BITS-1:0]   grp_mid;
  logic [SUM_BITS-1:0]   grp_hi;
  logic [SUM_BITS-1:0]   count_wide;
  logic [CNT_BITS-1:0]   grp_mid_c;
  logic [CNT_BITS-1:0]   grp_hi_c;
  logic [ADDR_BITS-1:0]  ra, rb, wa;
  logic                  we0, we1;
  logic [VALUE_BITS-1:0] wd;
  logic [CNT_BITS-1:0]   last_idx;

  mse_out_item_t out_item;
  logic          out_valid;

  assign full       = (count == CNT_BITS'(DEPTH));
  assign last_idx   = count - CNT_BITS'(1);
  assign take_left  = (a != mid) && ((b == hi) || (rd_a <= rd_b));
  assign merged     = take_left ? rd_a : rd_b;
  assign group_end  = (k == hi - CNT_BITS'(1));
  assign count_wide = SUM_BITS'(count);
  assign grp_base   = cmd.pass_init ? '0 : SUM_BITS'(hi);
  assign grp_mid    = grp_base + SUM_BITS'(width);
  assign grp_hi     = grp_mid + SUM_BITS'(width);
  assign grp_mid_c  = (grp_mid > count_wide) ? count : grp_mid[CNT_BITS-1:0];
  assign grp_hi_c   = (grp_hi > count_wide) ? count : grp_hi[CNT_BITS-1:0];

  assign status.sorted    = (width >= WID_BITS'(count));
  assign status.pass_last = (k == last_idx);
  assign status.emit_last = (a == last_idx);
  assign status.out_free  = !out_valid || result_ready;

  always_comb begin
    count_next = count;
    width_next = width;
    src_next   = src;
    a_next     = a;
    b_next     = b;
    k_next     = k;
    mid_next   = mid;
    hi_next    = hi;
    if (cmd.load && !full) begin
      count_next = count + CNT_BITS'(1);
    end
    if (cmd.sort_init) begin
      width_next = WID_BITS'(1);
      src_next   = 1'b0;
    end
    if (cmd.pass_init) begin
      a_next   = '0;
      k_next   = '0;
      mid_next = grp_mid_c;
      b_next   = grp_mid_c;
      hi_next  = grp_hi_c;
    end
    if (cmd.merge_step) begin
      k_next = k + CNT_BITS'(1);
      if (group_end) begin
        a_next   = hi;
        mid_next = grp_mid_c;
        b_next   = grp_mid_c;
        hi_next  = grp_hi_c;
      end else if (take_left) begin
        a_next = a + CNT_BITS'(1);
      end else begin
        b_next = b + CNT_BITS'(1);
      end
      if (status.pass_last) begin
        width_next = width << 1;
        src_next   = ~src;
      end
    end
    if (cmd.emit_init) begin
      a_next = '0;
    end
    if (cmd.emit_step) begin
      a_next = a + CNT_BITS'(1);
    end
    if (cmd.set_done) begin
      count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd.emit_step) begin
        out_valid <= 1'b1;
      end else if (result_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    width <= width_next;
    src   <= src_next;
    a     <= a_next;
    b     <= b_next;
    k     <= k_next;
    mid   <= mid_next;
    hi    <= hi_next;
    if (cmd.emit_step) begin
      out_item.sorted_value <= SAMPLE_BITS'(rd_a);
      out_item.end_of_set   <= status.emit_last;
    end
  end

  assign ra  = (a_next < CNT_BITS'(DEPTH)) ? a_next[ADDR_BITS-1:0] : '0;
  assign rb  = (b_next < CNT_BITS'(DEPTH)) ? b_next[ADDR_BITS-1:0] : '0;
  assign wa  = cmd.load ? count[ADDR_BITS-1:0] : k[ADDR_BITS-1:0];
  assign wd  = cmd.load ? VALUE_BITS'(load_item.sample) : merged;
  assign we0 = (cmd.load && !full) || (cmd.merge_step && src);
  assign we1 = cmd.merge_step && !src;

  always_ff @(posedge clk) begin
    if (we0) begin
      bank0[wa] <= wd;
    end
    if (we1) begin
      bank1[wa] <= wd;
    end
    rd_a <= src_next ? bank1[ra] : bank0[ra];
    rd_b <= src_next ? bank1[rb] : bank0[rb];
  end

  assign result_valid = out_valid;
  assign result_item  = out_item;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(DEPTH))
    else $error("loaded count beyond buffer depth");

  a_merge_source: assert property (@(posedge clk) disable iff (rst)
    cmd.merge_step |-> !((a == mid) && (b == hi)))
    else $error("merge step with both runs exhausted");

  a_pass_needed: assert property (@(posedge clk) disable iff (rst)
    cmd.pass_init |-> (width < WID_BITS'(count)))
    else $error("merge pass started on a sorted buffer");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_step |=> out_valid)
    else $error("emitted item not presented");
`endif

endmodule

// File: test/mse_checker.sv
`timescale 1ns / 1ps
// Scoreboard for merge_sort_engine_unit: predicts each sorted set and checks every result item.
module mse_checker
  import mse_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          load_valid,
  input  logic          load_ready,
  input  mse_in_item_t  load_item,
  input  logic          result_valid,
  input  logic          result_ready,
  input  mse_out_item_t result_item,
  output int            fail_count,
  output int            open_results
);

  localparam logic [SAMPLE_BITS-1:0] VALUE_MASK = SAMPLE_BITS'((64'd1 << VALUE_BITS) - 1);

  logic [SAMPLE_BITS-1:0] set_values [DEPTH];
  int                     set_size;
  mse_out_item_t          sorted_due [$];
  mse_out_item_t          want;

  task automatic close_set();
    logic [SAMPLE_BITS-1:0] held;
    int                     j;
    mse_out_item_t          item;
    for (int i = 1; i < set_size; i++) begin
      held = set_values[i];
      j = i - 1;
      while (j >= 0 && set_values[j] > held) begin
        set_values[j + 1] = set_values[j];
        j--;
      end
      set_values[j + 1] = held;
    end
    for (int i = 0; i < set_size; i++) begin
      item.sorted_value = set_values[i];
      item.end_of_set   = (i == set_size - 1);
      sorted_due = {sorted_due, item};
    end
    set_size = 0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      set_size = 0;
      sorted_due.delete();
      fail_count = 0;
      open_results = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (sorted_due.size() == 0) begin
          fail_count++;
          $display("%0t: result item with none pending: value=%h end_of_set=%b",
                   $time, result_item.sorted_value, result_item.end_of_set);
        end else begin
          want = sorted_due.pop_front();
          if (result_item.sorted_value !== want.sorted_value) begin
            fail_count++;
            $display("%0t: sorted_value mismatch: expected %h, actual %h",
                     $time, want.sorted_value, result_item.sorted_value);
          end
          if (result_item.end_of_set !== want.end_of_set) begin
            fail_count++;
            $display("%0t: end_of_set mismatch: expected %b, actual %b",
                     $time, want.end_of_set, result_item.end_of_set);
          end
        end
      end
      if (load_valid && load_ready) begin
        if (set_size < DEPTH) begin
          set_values[set_size] = load_item.sample & VALUE_MASK;
          set_size++;
        end
        if (load_item.final_item) begin
          close_set();
        end
      end
      open_results = sorted_due.size();
    end
  end

endmodule

// File: test/tb_merge_sort_engine_unit.sv
`timescale 1ns / 1ps
// Testbench top for merge_sort_engine_unit: bursty set stimulus, output stalls and verdict.
module tb_merge_sort_engine_unit;
  import mse_pkg::*;

  localparam int SET_CAP       = DEPTH_DEF;
  localparam int RANDOM_VALUES = 260;
  localparam int CYCLE_LIMIT   = 400000;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_EVERY_FOURTH,
    RX_TRICKLE
  } rx_mode_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          load_valid = 1'b0;
  logic          load_ready;
  mse_in_item_t  load_item = '0;
  logic          result_valid;
  logic          result_ready = 1'b0;
  mse_out_item_t result_item;

  int       fail_count;
  int       open_results;
  int       cycle_count = 0;
  int       burst_left = 0;
  int       loaded_values = 0;
  int       stall_span = 0;
  int       tick = 0;
  rx_mode_t stall_mode = RX_OPEN;

  always #10 clk = ~clk;

  merge_sort_engine_unit uut (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (load_valid),
    .load_ready   (load_ready),
    .load_item    (load_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

  mse_checker sort_check (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (load_valid),
    .load_ready   (load_ready),
    .load_item    (load_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item),
    .fail_count   (fail_count),
    .open_results (open_results)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** merge_sort_engine_unit: FAILED **");
      $finish;
    end
  end

  always @(negedge clk) begin
    tick <= tick + 1;
    if (stall_span == 0) begin
      stall_mode <= rx_mode_t'($urandom_range(0, 3));
      stall_span <= $urandom_range(16, 120);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      RX_OPEN:         result_ready <= 1'b1;
      RX_COIN:         result_ready <= ($urandom_range(0, 1) == 1);
      RX_EVERY_FOURTH: result_ready <= (tick % 4 == 0);
      default:         result_ready <= ($urandom_range(0, 11) == 0);
    endcase
  end

  task automatic send_value(input logic [SAMPLE_BITS-1:0] value, input logic last,
                            input bit drain);
    mse_in_item_t item;
    item.sample     = value;
    item.final_item = last;
    load_item  <= item;
    load_valid <= 1'b1;
    do @(posedge clk); while (!load_ready);
    @(negedge clk);
    if (drain || burst_left == 0) begin
      load_valid <= 1'b0;
      if (drain) begin
        while (open_results != 0) @(negedge clk);
      end
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(0, 24);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_random_set();
    int                     len;
    int                     pick;
    int                     style;
    bit                     drain;
    logic [SAMPLE_BITS-1:0] value;
    pick  = $urandom_range(0, 19);
    style = $urandom_range(0, 3);
    drain = ($urandom_range(0, 7) == 0);
    if (pick < 12) begin
      len = $urandom_range(1, SET_CAP);
    end else if (pick < 15) begin
      len = SET_CAP;
    end else if (pick < 17) begin
      len = $urandom_range(1, 3);
    end else begin
      len = $urandom_range(SET_CAP + 1, SET_CAP + 4);
    end
    for (int k = 0; k < len; k++) begin
      case (style)
        0:       value = SAMPLE_BITS'($urandom_range(0, 65535));
        1:       value = SAMPLE_BITS'($urandom_range(0, 3));
        2:       value = ($urandom_range(0, 1) == 1)
                         ? SAMPLE_BITS'(16'hFFFF - $urandom_range(0, 1))
                         : SAMPLE_BITS'($urandom_range(0, 1));
        default: value = 16'hFFF0 | SAMPLE_BITS'($urandom_range(0, 15));
      endcase
      send_value(value, k == len - 1, drain && k == len - 1);
    end
    loaded_values += (len < SET_CAP) ? len : SET_CAP;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    burst_left = $urandom_range(0, 24);

    send_value(16'hFFFF, 1'b1, 1'b0);
    send_value(16'hFFFF, 1'b0, 1'b0);
    send_value(16'h0000, 1'b1, 1'b0);
    for (int k = 0; k < 3; k++) begin
      send_value(16'h8000, k == 2, 1'b0);
    end
    for (int k = 0; k < SET_CAP; k++) begin
      send_value(16'hFFFF - 16'(k) * 16'h1111, 1'b0, 1'b0);
    end
    send_value(16'h1234, 1'b0, 1'b0);
    send_value(16'h4321, 1'b1, 1'b1);

    while (loaded_values < RANDOM_VALUES) begin
      send_random_set();
    end

    load_valid <= 1'b0;
    while (open_results != 0) @(negedge clk);
    repeat (120) @(negedge clk);
    if (fail_count == 0) begin
      $display("** merge_sort_engine_unit: PASSED **");
    end else begin
      $display("** merge_sort_engine_unit: FAILED **");
    end
    $finish;
  end

endmodule
